FILE: src/srlt_pkg.sv
// Package for the slice resource-block limit table.
// Holds request/result types, action and policy codes, table sizes and entry layouts.
// No dependencies.
package srlt_pkg;

	localparam int SLICE_ENTRIES = 16;
	localparam int UE_ENTRIES    = 64;
	localparam int SLICE_AW      = (SLICE_ENTRIES > 1) ? $clog2(SLICE_ENTRIES) : 1;
	localparam int UE_AW         = (UE_ENTRIES > 1) ? $clog2(UE_ENTRIES) : 1;

	localparam logic [2:0] ACT_LOOKUP = 3'd0;
	localparam logic [2:0] ACT_ADD    = 3'd1;
	localparam logic [2:0] ACT_DEL    = 3'd2;
	localparam logic [2:0] ACT_ASSOC  = 3'd3;
	localparam logic [2:0] ACT_UNLINK = 3'd4;

	localparam logic [1:0] POL_NVS    = 2'd0;
	localparam logic [1:0] POL_STATIC = 2'd1;
	localparam logic [1:0] POL_MINMAX = 2'd2;
	localparam logic [1:0] POL_NONE   = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] ue_id;
		logic [31:0] slice_key;
		logic [1:0]  algorithm;
		logic [8:0]  bandwidth_part_rbs;
		logic [16:0] reserved_share;
		logic [8:0]  range_first;
		logic [8:0]  range_last;
		logic [16:0] least_share;
		logic [16:0] most_share;
	} req_t;

	typedef struct packed {
		logic [8:0] max_blocks;
		logic [8:0] min_blocks;
		logic [8:0] static_low;
		logic [8:0] static_high;
		logic       static_found;
		logic       slice_found;
		logic       op_done;
	} rsp_t;

	typedef struct packed {
		logic [31:0] ident;
		logic [1:0]  policy;
		logic [16:0] most;
		logic [16:0] least;
		logic [16:0] reserved;
		logic [8:0]  last;
		logic [8:0]  first;
	} slice_ent_t;

	typedef struct packed {
		logic [15:0] rnti;
		logic [31:0] slice;
	} ue_ent_t;

	localparam int SLICE_W = $bits(slice_ent_t);
	localparam int UE_W    = $bits(ue_ent_t);

	// (rbs * share) >> 16, saturated to 9 bits
	function automatic logic [8:0] sat9(input logic [25:0] prod);
		logic [9:0] hi;
		hi = prod[25:16];
		return (hi > 10'd511) ? 9'd511 : hi[8:0];
	endfunction

endpackage

FILE: src/srlt_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module srlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: src/srlt_calc.sv
// Limit arithmetic for one looked-up slice entry: registered multiplies.
// Depends on srlt_pkg.
module srlt_calc (
	input  logic                  clk,
	input  logic                  load,
	input  srlt_pkg::slice_ent_t  ent,
	input  logic [8:0]            rbs,
	output srlt_pkg::rsp_t        rsp
);
	logic [25:0] pmax_q, pmin_q;
	logic [1:0]  pol_q;
	logic [8:0]  lo_q, hi_q;
	logic [8:0]  mx;
	logic [9:0]  span;

	always_ff @(posedge clk) begin
		if (load) begin
			pmax_q <= rbs * ((ent.policy == srlt_pkg::POL_MINMAX) ? ent.most : ent.reserved);
			pmin_q <= rbs * ent.least;
			pol_q  <= ent.policy;
			lo_q   <= ent.first;
			hi_q   <= ent.last;
		end
	end

	always_comb begin
		rsp = '0;
		rsp.slice_found = 1'b1;
		mx = srlt_pkg::sat9(pmax_q);
		span = {1'b0, hi_q} - {1'b0, lo_q} + 10'd1;
		unique case (pol_q)
			srlt_pkg::POL_NVS: rsp.max_blocks = (mx == 9'd0) ? 9'd1 : mx;
			srlt_pkg::POL_STATIC: begin
				rsp.max_blocks   = (hi_q >= lo_q) ? ((span > 10'd511) ? 9'd511 : span[8:0]) : 9'd0;
				rsp.static_low   = lo_q;
				rsp.static_high  = hi_q;
				rsp.static_found = 1'b1;
			end
			srlt_pkg::POL_MINMAX: begin
				rsp.max_blocks = (mx == 9'd0) ? 9'd1 : mx;
				rsp.min_blocks = srlt_pkg::sat9(pmin_q);
			end
			default: ;
		endcase
	end
endmodule

FILE: src/slice_rb_limit_table_top.sv
// Slice resource-block limit table, top level: sequencer, both table RAMs, limit unit.
// Depends on srlt_pkg, srlt_ram, srlt_calc.
//
// Usage: drive req and pulse start while busy is low; the request is taken at
// that edge and busy rises. Exactly one result appears on rsp for one cycle
// with done high; busy falls in the same cycle, so the next request may be
// started at the edge that ends it. The receiver cannot stall.
// Each request walks the UE RAM (UE_ENTRIES reads, one per cycle)
// and/or the slice RAM (SLICE_ENTRIES reads, one per cycle) through a
// single port each. A lookup walks the UE RAM and then, on a UE hit, the
// slice RAM; an add or delete walks only the slice RAM, an associate or
// unlink only the UE RAM, and an undefined action neither.
// The walk length is set by the single RAM ports.
// Reset clears both valid-bit vectors and the sequencer at once; the RAM
// contents are not cleared and are read only behind a set valid bit.
module slice_rb_limit_table_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  srlt_pkg::req_t   req,
	output logic             busy,
	output logic             done,
	output srlt_pkg::rsp_t   rsp
);
	localparam int SAW = srlt_pkg::SLICE_AW;
	localparam int UAW = srlt_pkg::UE_AW;

	typedef enum logic [3:0] {
		IDLE, UE_SCAN, UE_WB, SL_SCAN, CALC, SL_WR, FINISH
	} state_t;

	state_t              state_q;
	srlt_pkg::req_t      req_q;
	logic [SAW:0]        sidx_q;
	logic [UAW:0]        uidx_q;
	logic                rd_vld_q;
	logic [SAW-1:0]      s_rd_q;
	logic [UAW-1:0]      u_rd_q;
	logic                hit_q, free_q, chg_q;
	logic [SAW-1:0]      s_hit_q, s_free_q;
	logic [UAW-1:0]      u_hit_q, u_free_q;
	logic [31:0]         key_q;
	logic [srlt_pkg::SLICE_ENTRIES-1:0] svalid_q;
	logic [srlt_pkg::UE_ENTRIES-1:0]    uvalid_q;
	srlt_pkg::rsp_t      rsp_q;
	logic                done_q;

	logic                s_we, u_we;
	logic [SAW-1:0]      s_addr;
	logic [UAW-1:0]      u_addr;
	srlt_pkg::slice_ent_t s_wd, s_rd;
	srlt_pkg::ue_ent_t   u_wd, u_rd;
	srlt_pkg::rsp_t      calc_rsp;
	logic                calc_load;

	srlt_ram #(.WIDTH(srlt_pkg::SLICE_W), .DEPTH(srlt_pkg::SLICE_ENTRIES)) u_slice_ram (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd)
	);
	srlt_ram #(.WIDTH(srlt_pkg::UE_W), .DEPTH(srlt_pkg::UE_ENTRIES)) u_ue_ram (
		.clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wd), .rdata(u_rd)
	);
	srlt_calc u_calc (
		.clk(clk), .load(calc_load), .ent(s_rd), .rbs(req_q.bandwidth_part_rbs), .rsp(calc_rsp)
	);

	// read-side match on the entry read last cycle
	logic s_match, u_match, u_unl;
	assign s_match = rd_vld_q && svalid_q[s_rd_q] && (s_rd.ident == key_q);
	assign u_match = rd_vld_q && uvalid_q[u_rd_q] && (u_rd.rnti == req_q.ue_id);
	assign u_unl   = rd_vld_q && uvalid_q[u_rd_q] && (u_rd.slice == req_q.slice_key);
	assign calc_load = (state_q == SL_SCAN) && s_match && !hit_q;

	always_comb begin
		s_we = 1'b0;
		u_we = 1'b0;
		s_addr = sidx_q[SAW-1:0];
		u_addr = uidx_q[UAW-1:0];
		s_wd.ident    = key_q;
		s_wd.policy   = req_q.algorithm;
		s_wd.most     = req_q.most_share;
		s_wd.least    = req_q.least_share;
		s_wd.reserved = req_q.reserved_share;
		s_wd.last     = req_q.range_last;
		s_wd.first    = req_q.range_first;
		u_wd.rnti  = req_q.ue_id;
		u_wd.slice = req_q.slice_key;
		if (state_q == SL_WR) begin
			s_we = hit_q || free_q;
			s_addr = hit_q ? s_hit_q : s_free_q;
		end
		if (state_q == UE_WB) begin
			u_we = (req_q.action == srlt_pkg::ACT_ASSOC) && (hit_q || free_q);
			u_addr = hit_q ? u_hit_q : u_free_q;
		end
	end

	assign busy = (state_q != IDLE) && !done_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			svalid_q <= '0;
			uvalid_q <= '0;
			done_q   <= 1'b0;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			chg_q    <= 1'b0;
			sidx_q   <= '0;
			uidx_q   <= '0;
			rsp_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (start) begin
						req_q  <= req;
						key_q  <= req.slice_key;
						sidx_q <= '0;
						uidx_q <= '0;
						rd_vld_q <= 1'b0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						chg_q  <= 1'b0;
						rsp_q  <= '0;
						unique case (req.action) inside
							srlt_pkg::ACT_LOOKUP, srlt_pkg::ACT_ASSOC,
							srlt_pkg::ACT_UNLINK: state_q <= UE_SCAN;
							srlt_pkg::ACT_ADD, srlt_pkg::ACT_DEL: state_q <= SL_SCAN;
							default: state_q <= FINISH;
						endcase
					end
				end
				UE_SCAN: begin
					// advance address; evaluate entry read last cycle
					if (uidx_q < (UAW+1)'(srlt_pkg::UE_ENTRIES)) begin
						u_rd_q   <= uidx_q[UAW-1:0];
						uidx_q   <= uidx_q + 1'b1;
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
					end
					if (rd_vld_q) begin
						if (req_q.action == srlt_pkg::ACT_UNLINK) begin
							if (u_unl) begin
								uvalid_q[u_rd_q] <= 1'b0;
								chg_q <= 1'b1;
							end
						end else begin
							if (u_match && !hit_q) begin
								hit_q   <= 1'b1;
								u_hit_q <= u_rd_q;
								key_q   <= u_rd.slice;
							end
						end
						if (!uvalid_q[u_rd_q] && !free_q) begin
							free_q   <= 1'b1;
							u_free_q <= u_rd_q;
						end
					end
					if (!rd_vld_q && uidx_q == (UAW+1)'(srlt_pkg::UE_ENTRIES)) begin
						state_q <= UE_WB;
					end
				end
				UE_WB: begin
					if (req_q.action == srlt_pkg::ACT_ASSOC) begin
						if (hit_q || free_q) begin
							uvalid_q[hit_q ? u_hit_q : u_free_q] <= 1'b1;
							chg_q <= 1'b1;
						end
						state_q <= FINISH;
					end else if (req_q.action == srlt_pkg::ACT_LOOKUP) begin
						free_q <= 1'b0;
						rd_vld_q <= 1'b0;
						sidx_q <= '0;
						state_q <= hit_q ? SL_SCAN : FINISH;
						hit_q <= 1'b0;
					end else begin
						state_q <= FINISH;
					end
				end
				SL_SCAN: begin
					if (sidx_q < (SAW+1)'(srlt_pkg::SLICE_ENTRIES)) begin
						s_rd_q   <= sidx_q[SAW-1:0];
						sidx_q   <= sidx_q + 1'b1;
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
					end
					if (rd_vld_q) begin
						if (s_match && !hit_q) begin
							hit_q   <= 1'b1;
							s_hit_q <= s_rd_q;
						end
						if (!svalid_q[s_rd_q] && !free_q) begin
							free_q   <= 1'b1;
							s_free_q <= s_rd_q;
						end
					end
					if (!rd_vld_q && sidx_q == (SAW+1)'(srlt_pkg::SLICE_ENTRIES)) begin
						unique case (req_q.action)
							srlt_pkg::ACT_ADD: state_q <= SL_WR;
							srlt_pkg::ACT_DEL: begin
								if (hit_q) begin
									svalid_q[s_hit_q] <= 1'b0;
									chg_q <= 1'b1;
								end
								state_q <= FINISH;
							end
							default: state_q <= hit_q ? CALC : FINISH;
						endcase
					end
				end
				SL_WR: begin
					if (hit_q || free_q) begin
						svalid_q[hit_q ? s_hit_q : s_free_q] <= 1'b1;
						chg_q <= 1'b1;
					end
					state_q <= FINISH;
				end
				CALC: begin
					rsp_q   <= calc_rsp;
					done_q  <= 1'b1;
					state_q <= IDLE;
				end
				FINISH: begin
					// rsp_q was cleared when the request was taken
					rsp_q.op_done <= chg_q && (req_q.action != srlt_pkg::ACT_LOOKUP);
					done_q  <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

FILE: src/srlt_checker.sv
// Port-level checker for the slice resource-block limit table, bound to the top.
// Depends on srlt_pkg and slice_rb_limit_table_top.
module srlt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input srlt_pkg::rsp_t rsp
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held over one cycle");
	a_write_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.op_done |-> !rsp.slice_found && rsp.max_blocks == 9'd0)
		else $error("write result carries lookup fields");
	a_static: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.static_found |-> rsp.slice_found) else $error("static without slice");
endmodule

bind slice_rb_limit_table_top srlt_checker u_srlt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

FILE: tb/sv/slice_rb_limit_table_top_test.sv
// Testbench for the slice resource-block limit table top level.
// Drives requests on the start/busy handshake, predicts each result and checks it.
// Depends on srlt_pkg and slice_rb_limit_table_top.
`timescale 1ns / 100ps

module slice_rb_limit_table_top_test;

	class limit_scoreboard;
		logic         s_valid [srlt_pkg::SLICE_ENTRIES];
		logic [31:0]  s_ident [srlt_pkg::SLICE_ENTRIES];
		logic [1:0]   s_policy [srlt_pkg::SLICE_ENTRIES];
		logic [16:0]  s_resv [srlt_pkg::SLICE_ENTRIES];
		logic [16:0]  s_least [srlt_pkg::SLICE_ENTRIES];
		logic [16:0]  s_most [srlt_pkg::SLICE_ENTRIES];
		logic [8:0]   s_first [srlt_pkg::SLICE_ENTRIES];
		logic [8:0]   s_last [srlt_pkg::SLICE_ENTRIES];
		logic         u_valid [srlt_pkg::UE_ENTRIES];
		logic [15:0]  u_rnti [srlt_pkg::UE_ENTRIES];
		logic [31:0]  u_slice [srlt_pkg::UE_ENTRIES];
		srlt_pkg::rsp_t pending [$];
		int           errors;

		function new();
			errors = 0;
			for (int i = 0; i < srlt_pkg::SLICE_ENTRIES; i++) s_valid[i] = 0;
			for (int i = 0; i < srlt_pkg::UE_ENTRIES; i++) u_valid[i] = 0;
		endfunction

		function logic [8:0] scaled_blocks(logic [8:0] rbs, logic [16:0] share);
			logic [25:0] prod;
			prod = rbs * share;
			return (prod[25:16] > 10'd511) ? 9'd511 : prod[24:16];
		endfunction

		function int slice_index(logic [31:0] key);
			for (int i = 0; i < srlt_pkg::SLICE_ENTRIES; i++)
				if (s_valid[i] && s_ident[i] == key) return i;
			return -1;
		endfunction

		function int ue_index(logic [15:0] rnti);
			for (int i = 0; i < srlt_pkg::UE_ENTRIES; i++)
				if (u_valid[i] && u_rnti[i] == rnti) return i;
			return -1;
		endfunction

		function void note_request(srlt_pkg::req_t r);
			srlt_pkg::rsp_t e;
			int s, u;
			e = '0;
			case (r.action)
				srlt_pkg::ACT_LOOKUP: begin
					u = ue_index(r.ue_id);
					s = (u >= 0) ? slice_index(u_slice[u]) : -1;
					if (s >= 0) begin
						e.slice_found = 1;
						case (s_policy[s])
							srlt_pkg::POL_NVS: begin
								e.max_blocks = scaled_blocks(r.bandwidth_part_rbs, s_resv[s]);
								if (e.max_blocks == 0) e.max_blocks = 1;
							end
							srlt_pkg::POL_STATIC: begin
								e.max_blocks = (s_last[s] >= s_first[s]) ?
									9'(s_last[s] - s_first[s] + 1) : 9'd0;
								e.static_low = s_first[s];
								e.static_high = s_last[s];
								e.static_found = 1;
							end
							srlt_pkg::POL_MINMAX: begin
								e.max_blocks = scaled_blocks(r.bandwidth_part_rbs, s_most[s]);
								if (e.max_blocks == 0) e.max_blocks = 1;
								e.min_blocks = scaled_blocks(r.bandwidth_part_rbs, s_least[s]);
							end
							default: ;
						endcase
					end
				end
				srlt_pkg::ACT_ADD: begin
					s = slice_index(r.slice_key);
					if (s < 0)
						for (int i = 0; i < srlt_pkg::SLICE_ENTRIES; i++)
							if (!s_valid[i]) begin
								s = i;
								s_valid[i] = 1;
								s_ident[i] = r.slice_key;
								break;
							end
					if (s >= 0) begin
						s_policy[s] = r.algorithm;
						s_resv[s] = r.reserved_share;
						s_least[s] = r.least_share;
						s_most[s] = r.most_share;
						s_first[s] = r.range_first;
						s_last[s] = r.range_last;
						e.op_done = 1;
					end
				end
				srlt_pkg::ACT_DEL: begin
					s = slice_index(r.slice_key);
					if (s >= 0) begin
						s_valid[s] = 0;
						e.op_done = 1;
					end
				end
				srlt_pkg::ACT_ASSOC: begin
					u = ue_index(r.ue_id);
					if (u < 0)
						for (int i = 0; i < srlt_pkg::UE_ENTRIES; i++)
							if (!u_valid[i]) begin
								u = i;
								u_valid[i] = 1;
								u_rnti[i] = r.ue_id;
								break;
							end
					if (u >= 0) begin
						u_slice[u] = r.slice_key;
						e.op_done = 1;
					end
				end
				srlt_pkg::ACT_UNLINK: begin
					for (int i = 0; i < srlt_pkg::UE_ENTRIES; i++)
						if (u_valid[i] && u_slice[i] == r.slice_key) begin
							u_valid[i] = 0;
							e.op_done = 1;
						end
				end
				default: ;
			endcase
			pending.push_back(e);
		endfunction

		function void check_result(srlt_pkg::rsp_t a);
			srlt_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("result with nothing pending: %p", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.max_blocks !== e.max_blocks) begin
				$error("max_blocks exp %0d got %0d", e.max_blocks, a.max_blocks); errors++;
			end
			if (a.min_blocks !== e.min_blocks) begin
				$error("min_blocks exp %0d got %0d", e.min_blocks, a.min_blocks); errors++;
			end
			if (a.static_low !== e.static_low) begin
				$error("static_low exp %0d got %0d", e.static_low, a.static_low); errors++;
			end
			if (a.static_high !== e.static_high) begin
				$error("static_high exp %0d got %0d", e.static_high, a.static_high); errors++;
			end
			if (a.static_found !== e.static_found) begin
				$error("static_found exp %0b got %0b", e.static_found, a.static_found);
				errors++;
			end
			if (a.slice_found !== e.slice_found) begin
				$error("slice_found exp %0b got %0b", e.slice_found, a.slice_found); errors++;
			end
			if (a.op_done !== e.op_done) begin
				$error("op_done exp %0b got %0b", e.op_done, a.op_done); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	srlt_pkg::req_t req = '0;
	logic busy, done;
	srlt_pkg::rsp_t rsp;
	limit_scoreboard sb = new();
	int cycles = 0;
	bit quiet = 0;
	logic [31:0] keys [8];
	logic [15:0] rntis [8];

	slice_rb_limit_table_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1000000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done) sb.check_result(rsp);

	// hold start until the request is taken; the next call drops it when it idles
	task automatic send(srlt_pkg::req_t r);
		if (!quiet)
			while ($urandom_range(99) < 8) begin
				start <= 0;
				@(posedge clk);
			end
		start <= 1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
	endtask

	// drop start and hold off until every expected result has come
	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic srlt_pkg::req_t rand_req();
		srlt_pkg::req_t r;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		r = srlt_pkg::req_t'(raw[$bits(srlt_pkg::req_t)-1:0]);
		r.action = $urandom_range(99) < 4 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
		r.bandwidth_part_rbs = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(275));
		if ($urandom_range(3) != 0) begin
			r.ue_id = rntis[$urandom_range(7)];
			r.slice_key = keys[$urandom_range(7)];
		end
		if ($urandom_range(3) != 0) begin
			r.reserved_share = 17'($urandom_range(65536));
			r.least_share = 17'($urandom_range(65536));
			r.most_share = 17'($urandom_range(65536));
			r.range_first = 9'($urandom_range(275));
			r.range_last = 9'($urandom_range(275));
		end
		return r;
	endfunction

	function automatic srlt_pkg::req_t mk(logic [2:0] act, logic [15:0] ue, logic [31:0] key,
		logic [1:0] alg, logic [8:0] bwp);
		srlt_pkg::req_t r;
		r = '0;
		r.action = act; r.ue_id = ue; r.slice_key = key;
		r.algorithm = alg; r.bandwidth_part_rbs = bwp;
		return r;
	endfunction

	initial begin
		srlt_pkg::req_t r;
		for (int i = 0; i < 8; i++) begin
			keys[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom;
			rntis[i] = (i == 0) ? 16'hFFFF : 16'($urandom);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: each policy, extremes, undefined action, absent deletes
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 275));
		send(mk(srlt_pkg::ACT_DEL, 0, 32'hFFFF_FFFF, 0, 0));
		send(mk(srlt_pkg::ACT_UNLINK, 0, 32'hFFFF_FFFF, 0, 0));
		r = mk(srlt_pkg::ACT_ADD, 0, 32'hFFFF_FFFF, srlt_pkg::POL_NVS, 0);
		r.reserved_share = 17'd65536;
		send(r);
		send(mk(srlt_pkg::ACT_ASSOC, 16'hFFFF, 32'hFFFF_FFFF, 0, 0));
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 9'd275));
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 9'd511));
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 9'd0));
		r = mk(srlt_pkg::ACT_ADD, 0, 32'hFFFF_FFFF, srlt_pkg::POL_STATIC, 0);
		r.range_first = 9'd275; r.range_last = 9'd0; send(r);
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 9'd100));
		r.range_first = 0; r.range_last = 9'd275; send(r);
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 9'd100));
		r = mk(srlt_pkg::ACT_ADD, 0, 32'hFFFF_FFFF, srlt_pkg::POL_MINMAX, 0);
		r.least_share = 17'h1FFFF; r.most_share = 17'd1; send(r);
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 9'd511));
		send(mk(srlt_pkg::ACT_ADD, 0, 32'hFFFF_FFFF, srlt_pkg::POL_NONE, 0));
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 9'd200));
		send(mk(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 3, 9'h1FF));
		send(mk(srlt_pkg::ACT_DEL, 0, 32'hFFFF_FFFF, 0, 0));
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 9'd200));
		send(mk(srlt_pkg::ACT_UNLINK, 0, 32'hFFFF_FFFF, 0, 0));
		send(mk(srlt_pkg::ACT_LOOKUP, 16'hFFFF, 0, 0, 9'd200));

		// fill both tables past capacity
		for (int i = 0; i < srlt_pkg::SLICE_ENTRIES + 2; i++)
			send(mk(srlt_pkg::ACT_ADD, 0, 32'(i + 100), 2'(i), 9'd0));
		for (int i = 0; i < srlt_pkg::UE_ENTRIES + 2; i++)
			send(mk(srlt_pkg::ACT_ASSOC, 16'(i + 1000), 32'(100 + i % 20), 0, 0));
		drain();
		for (int i = 0; i < srlt_pkg::UE_ENTRIES + 2; i += 7)
			send(mk(srlt_pkg::ACT_LOOKUP, 16'(i + 1000), 0, 0, 9'($urandom_range(275))));
		for (int i = 0; i < 20; i++) begin
			send(mk(srlt_pkg::ACT_UNLINK, 0, 32'(100 + i), 0, 0));
			send(mk(srlt_pkg::ACT_DEL, 0, 32'(100 + i), 0, 0));
		end

		for (int n = 0; n < 1800; n++) begin
			quiet = (n >= 600 && n < 900);
			if (n == 1200) drain();
			send(rand_req());
		end
		quiet = 0;
		drain();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
